FILE: design/isa_pkg.sv
// Shared definitions for the interval slot allocator.
// Holds default sizes, field widths, result codes and the controller command word.
// No dependencies.
`default_nettype none

package isa_pkg;

  // Default sizes handed to the top level parameters.
  localparam int SlotsDefault  = 64;
  localparam int IdBitsDefault = 16;

  // Fixed widths of the port fields.
  localparam int IN_ID_W      = 16;
  localparam int SLOT_INDEX_W = 6;
  localparam int SLOTS_USED_W = 7;
  localparam int STATUS_W     = 2;

  // A pair value takes two adjacent, even-aligned slots.
  localparam int PAIR_SIZE = 2;

  // Width of one group of the two-level free-slot search.
  localparam int GROUP_W = 16;

  // Codes of the action field.
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_CLEAR = 1'b1;

  // Codes of the status field.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOC   = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_CLEARED = 2'd2
  } status_t;

  // Commands from the controller to the datapath, one per step.
  typedef struct packed {
    logic load;
    logic expire;
    logic scan;
    logic pick;
    logic commit;
    logic clear;
  } isa_cmd_t;

endpackage

`default_nettype wire

FILE: design/isa_ctrl.sv
// Controller of the interval slot allocator: sequences each word through its steps.
// Depends on isa_pkg for the command word and action codes.
`default_nettype none

module isa_ctrl import isa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     action,
  output isa_cmd_t      cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXPIRE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_PICK   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_CLEAR  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Next state: an allocation walks expire, scan, pick and commit; a clear takes one step.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action == ACTION_CLEAR) ? S_CLEAR : S_EXPIRE;
        end
      end
      S_EXPIRE: state_next = S_SCAN;
      S_SCAN:   state_next = S_PICK;
      S_PICK:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      S_CLEAR:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_COMMIT) || (state == S_CLEAR);
    end
  end

  // Commands decoded from the state.
  always_comb begin
    cmd.load   = accept;
    cmd.expire = (state == S_EXPIRE);
    cmd.scan   = (state == S_SCAN);
    cmd.pick   = (state == S_PICK);
    cmd.commit = (state == S_COMMIT);
    cmd.clear  = (state == S_CLEAR);
  end

endmodule

`default_nettype wire

FILE: design/isa_dp.sv
// Datapath of the interval slot allocator: slot table, expiry, free-slot search and commit.
// Depends on isa_pkg; driven by the command word of isa_ctrl.
`default_nettype none

module isa_dp import isa_pkg::*; #(
  parameter int SLOTS   = SlotsDefault,
  parameter int ID_BITS = IdBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire isa_cmd_t                cmd,
  input  wire logic [IN_ID_W-1:0]      interval_start,
  input  wire logic [IN_ID_W-1:0]      interval_end,
  input  wire logic                    needs_pair,
  output logic      [SLOT_INDEX_W-1:0] slot_index,
  output logic      [STATUS_W-1:0]     status,
  output logic      [SLOTS_USED_W-1:0] slots_used
);

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int MARK_W  = $clog2(SLOTS + 1);
  localparam int MW1     = MARK_W + 1;
  localparam int NG      = (SLOTS + GROUP_W - 1) / GROUP_W;
  localparam int GI_W    = (NG > 1) ? $clog2(NG) : 1;
  localparam int LOW_W   = $clog2(GROUP_W);
  localparam int FOUND_W = GI_W + LOW_W;

  // Interval word, ids brought to ID_BITS.
  logic [ID_BITS+IN_ID_W-1:0] start_ext;
  logic [ID_BITS+IN_ID_W-1:0] end_ext;
  logic [ID_BITS-1:0]         start_id;
  logic [ID_BITS-1:0]         end_id;
  logic                       pair_q;

  // Slot table and high-water mark.
  logic [SLOTS-1:0]   slot_busy;
  logic [ID_BITS-1:0] slot_owner_end [SLOTS];
  logic [MARK_W-1:0]  hwm;
  logic [MW1-1:0]     mark_ext;

  // Search pipeline.
  logic [NG*GROUP_W-1:0] vec_pad;
  logic [NG-1:0]         grp_hit;
  logic [NG-1:0]         grp_hit_d;
  logic [LOW_W-1:0]      grp_low   [NG];
  logic [LOW_W-1:0]      grp_low_d [NG];
  logic                  found;
  logic                  found_d;
  logic [FOUND_W-1:0]    found_idx;
  logic [FOUND_W-1:0]    found_idx_d;

  // Commit decision.
  logic [MW1-1:0]    pair_base;
  logic [MW1-1:0]    pair_slot;
  logic [MW1-1:0]    grow_slot;
  logic [MW1-1:0]    grow_top;
  logic              take;
  logic [SLOT_W-1:0] sel_slot;
  logic [SLOT_W-1:0] sel_slot_hi;
  logic [MARK_W-1:0] hwm_commit;

  // Output field conversion.
  logic [SLOT_W+SLOT_INDEX_W-1:0] sel_ext;
  logic [MARK_W+SLOTS_USED_W-1:0] used_new_ext;
  logic [MARK_W+SLOTS_USED_W-1:0] used_old_ext;

  assign start_ext = {{ID_BITS{1'b0}}, interval_start};
  assign end_ext   = {{ID_BITS{1'b0}}, interval_end};

  // Latch the interval word when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_id <= start_ext[ID_BITS-1:0];
      end_id   <= end_ext[ID_BITS-1:0];
      pair_q   <= needs_pair;
    end
  end

  assign mark_ext = {1'b0, hwm};

  // Candidate vector: free singles below the mark, or free aligned pairs below the mark.
  for (genvar i = 0; i < SLOTS; i++) begin : g_vec
    if ((i % PAIR_SIZE == 0) && (i + 1 < SLOTS)) begin : g_pair
      assign vec_pad[i] = pair_q
        ? (!slot_busy[i] && !slot_busy[i+1] && (MW1'(i + 1) < mark_ext))
        : (!slot_busy[i] && (MW1'(i) < mark_ext));
    end else begin : g_single
      assign vec_pad[i] = pair_q ? 1'b0 : (!slot_busy[i] && (MW1'(i) < mark_ext));
    end
  end
  for (genvar i = SLOTS; i < NG * GROUP_W; i++) begin : g_pad
    assign vec_pad[i] = 1'b0;
  end

  // First level of the search: lowest candidate inside each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_low_d[g] = '0;
      for (int b = GROUP_W - 1; b >= 0; b--) begin
        if (vec_pad[g*GROUP_W + b]) begin
          grp_hit_d[g] = 1'b1;
          grp_low_d[g] = LOW_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      grp_hit <= grp_hit_d;
      grp_low <= grp_low_d;
    end
  end

  // Second level of the search: lowest group with a candidate.
  always_comb begin
    found_d     = 1'b0;
    found_idx_d = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        found_d     = 1'b1;
        found_idx_d = {GI_W'(g), grp_low[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      found     <= found_d;
      found_idx <= found_idx_d;
    end
  end

  // Growth at the mark; a pair rounds up to the next even slot.
  assign pair_base  = mark_ext + MW1'(1);
  assign pair_slot  = {pair_base[MW1-1:1], 1'b0};
  assign grow_slot  = pair_q ? pair_slot : mark_ext;
  assign grow_top   = pair_q ? (pair_slot + MW1'(PAIR_SIZE)) : (mark_ext + MW1'(1));
  assign take       = found || (grow_top <= MW1'(SLOTS));
  assign sel_slot   = found ? found_idx[SLOT_W-1:0] : grow_slot[SLOT_W-1:0];
  assign sel_slot_hi = sel_slot | SLOT_W'(1);
  assign hwm_commit = found ? hwm : grow_top[MARK_W-1:0];

  // Busy flags: cleared, expired, or set by a commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
    end else if (cmd.clear) begin
      slot_busy <= '0;
    end else if (cmd.expire) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_busy[i] && (slot_owner_end[i] < start_id)) begin
          slot_busy[i] <= 1'b0;
        end
      end
    end else if (cmd.commit && take) begin
      for (int i = 0; i < SLOTS; i++) begin
        if ((SLOT_W'(i) == sel_slot) || (pair_q && (SLOT_W'(i) == sel_slot_hi))) begin
          slot_busy[i] <= 1'b1;
        end
      end
    end
  end

  // Owner end ids, written for every slot that becomes busy.
  always_ff @(posedge clk) begin
    if (cmd.commit && take) begin
      for (int i = 0; i < SLOTS; i++) begin
        if ((SLOT_W'(i) == sel_slot) || (pair_q && (SLOT_W'(i) == sel_slot_hi))) begin
          slot_owner_end[i] <= end_id;
        end
      end
    end
  end

  // High-water mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      hwm <= '0;
    end else if (cmd.clear) begin
      hwm <= '0;
    end else if (cmd.commit && take) begin
      hwm <= hwm_commit;
    end
  end

  assign sel_ext      = {{SLOT_INDEX_W{1'b0}}, sel_slot};
  assign used_new_ext = {{SLOTS_USED_W{1'b0}}, hwm_commit};
  assign used_old_ext = {{SLOTS_USED_W{1'b0}}, hwm};

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      slot_index <= '0;
      status     <= STATUS_CLEARED;
      slots_used <= '0;
    end else if (cmd.commit) begin
      if (take) begin
        slot_index <= sel_ext[SLOT_INDEX_W-1:0];
        status     <= STATUS_ALLOC;
        slots_used <= used_new_ext[SLOTS_USED_W-1:0];
      end else begin
        slot_index <= '0;
        status     <= STATUS_FULL;
        slots_used <= used_old_ext[SLOTS_USED_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  // The mark never passes the slot count.
  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    hwm <= MARK_W'(SLOTS))
    else $error("high-water mark beyond slot count");

  // A clear leaves every slot free and the mark at zero.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (hwm == '0) && (slot_busy == '0))
    else $error("clear left slots busy");

  // A placed interval owns its slot afterwards.
  a_take: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && take) |=> slot_busy[$past(sel_slot)])
    else $error("allocated slot not busy");

  // A pair starts on an even slot and its upper half is busy.
  a_pair_both: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && take && pair_q) |=>
      (slot_busy[$past(sel_slot_hi)] && ($past(sel_slot[0]) == 1'b0)))
    else $error("pair not aligned or not fully busy");

  // Only a clear lowers the mark.
  a_mark_grows: assert property (@(posedge clk) disable iff (rst)
    !cmd.clear |=> (hwm >= $past(hwm)))
    else $error("high-water mark dropped without clear");
`endif

endmodule

`default_nettype wire

FILE: design/interval_slot_allocator.sv
// Top level of the interval slot allocator: controller plus slot datapath.
// Depends on isa_pkg, isa_ctrl and isa_dp.
//
//   channel   ports                                              handshake
//   ------    -------------------------------------------------  ----------------------
//   input     action interval_start interval_end needs_pair      start high, busy low
//   result    slot_index status slots_used                       done high, one cycle
//
// An allocation runs from accept through expiry of all slots, group search, group
// select, then commit; done rises the cycle after commit. A clear takes one step.
// busy holds off a new word until the last one is finished.
// Reset is synchronous and frees every slot and zeroes the mark at once.
// The receiver cannot stall; each result word is marked by done for exactly one cycle.
`default_nettype none

module interval_slot_allocator import isa_pkg::*; #(
  parameter int SLOTS   = SlotsDefault,
  parameter int ID_BITS = IdBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    action,
  input  wire logic [IN_ID_W-1:0]      interval_start,
  input  wire logic [IN_ID_W-1:0]      interval_end,
  input  wire logic                    needs_pair,
  output logic                         done,
  output logic      [SLOT_INDEX_W-1:0] slot_index,
  output logic      [STATUS_W-1:0]     status,
  output logic      [SLOTS_USED_W-1:0] slots_used
);

  isa_cmd_t cmd;

  // Step sequencer.
  isa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Slot table, search and result word.
  isa_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .needs_pair     (needs_pair),
    .slot_index     (slot_index),
    .status         (status),
    .slots_used     (slots_used)
  );

endmodule

`default_nettype wire
